// ----- design/list_lookup_first_index_core_macros.svh -----
`ifndef LIST_LOOKUP_FIRST_INDEX_CORE_MACROS_SVH
`define LIST_LOOKUP_FIRST_INDEX_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LLFI_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("llfi assertion failed");

// Next-cycle implication, checked outside reset.
`define LLFI_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("llfi assertion failed");

`endif

// ----- design/llfi_pkg.sv -----
package llfi_pkg;

  // Operation codes.
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_PROBE  = 2'd2;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int KEY_BITS_DEF    = 64;
  localparam int KEY_W           = 64;
  localparam int POS_W           = 10;

  typedef struct packed {
    logic [1:0]       operation;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             overflow;
  } rsp_t;

endpackage

// ----- design/llfi_ram.sv -----
module llfi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/llfi_front.sv -----
module llfi_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  llfi_pkg::req_t req,
  output logic          q_valid,
  input  logic          q_pop,
  output llfi_pkg::req_t q_item
);
  import llfi_pkg::*;

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;

  // Accept transactions until both slots hold work for the back end.
  assign req_stall = (fill == 2'd2);
  assign push      = req_valid && !req_stall;
  assign q_valid   = (fill != 2'd0);
  assign q_item    = slots[rd_ptr];

  // Each accepted transaction goes unchanged into the slot the write pointer selects.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end

endmodule

// ----- design/llfi_back.sv -----
`include "list_lookup_first_index_core_macros.svh"

module llfi_back #(
  parameter int TABLE_DEPTH = llfi_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = llfi_pkg::KEY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_pop,
  input  llfi_pkg::req_t q_item,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output llfi_pkg::rsp_t rsp
);
  import llfi_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]          state;
  logic [1:0]          op;
  logic [KEY_BITS-1:0] key;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       count;
  logic                hit;
  logic [KEY_BITS-1:0] rdata;
  logic                we;
  logic                full;

  assign full  = (count == CW'(TABLE_DEPTH));
  assign q_pop = (state == S_IDLE) && q_valid && !rsp_valid;
  assign we    = (state == S_DONE) && (op == OP_INSERT) && !full;

  llfi_ram #(.WIDTH(KEY_BITS), .DEPTH(TABLE_DEPTH)) u_keys (
    .clk   (clk),
    .we    (we),
    .waddr (count[AW-1:0]),
    .wdata (key),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  // Payload of the item in work.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      op  <= q_item.operation;
      key <= q_item.key[KEY_BITS-1:0];
    end
  end

  // Linear scan from position zero; the first equal key is the first occurrence.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      idx       <= '0;
      hit       <= 1'b0;
      rsp_valid <= 1'b0;
      rsp       <= '0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            idx <= '0;
            hit <= 1'b0;
            if ((q_item.operation == OP_INSERT || q_item.operation == OP_PROBE)
                && count != '0) begin
              state <= S_READ;
            end else begin
              if (q_item.operation == OP_CLEAR) begin
                count <= '0;
              end
              state <= S_DONE;
            end
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (rdata == key) begin
            hit   <= 1'b1;
            state <= S_DONE;
          end else if (idx + CW'(1) == count) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_READ;
          end
        end
        S_DONE: begin
          rsp_valid    <= 1'b1;
          rsp.found    <= hit;
          rsp.position <= hit ? POS_W'(idx) : '0;
          rsp.overflow <= (op == OP_INSERT) && full;
          if (we) begin
            count <= count + CW'(1);
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Consistency checks.
  `LLFI_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(TABLE_DEPTH))
  `LLFI_ASSERT_NOW(a_miss_pos_zero, rsp_valid && !rsp.found, rsp.position == '0)
  `LLFI_ASSERT_NEXT(a_pop_when_free, q_pop, !rsp_valid && state != S_IDLE)
  `LLFI_ASSERT_NOW(a_scan_in_range, state == S_CMP, idx < count)

endmodule

// ----- design/list_lookup_first_index_core.sv -----
// Clear, unused codes and any lookup on an empty table go straight to the response;
// otherwise the back end scans up to the fill count of entries, each in a READ then
// a CMP state. The back end takes one transaction at a time, and none while a
// response is held; the key RAM read port sets the scan rate.
// A two-entry queue buffers input.
// Reset (synchronous, active high) empties the table and queue; no clearing pass.
module list_lookup_first_index_core #(
  parameter int TABLE_DEPTH = llfi_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_BITS    = llfi_pkg::KEY_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  llfi_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output llfi_pkg::rsp_t rsp
);
  import llfi_pkg::*;

  logic q_valid;
  logic q_pop;
  req_t q_item;

  // Front end: input queue.
  llfi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  // Back end: table search and update.
  llfi_back #(.TABLE_DEPTH(TABLE_DEPTH), .KEY_BITS(KEY_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
